/* hdl/sngh_pkg.sv */
`timescale 1ns / 1ps

package sngh_pkg;

   // sample and envelope formats
   localparam int SAMPLE_W  = 24;
   localparam int ENV_EXTRA = 16;
   localparam int ENV_W     = SAMPLE_W + ENV_EXTRA;

   // register widths
   localparam int THR_W   = 23;
   localparam int ALPHA_W = 17;
   localparam int HOLD_W  = 18;
   localparam int CSR_W   = 23;
   localparam int IDX_W   = 2;

   // number of main audio lanes
   localparam int MAIN_LANES = 2;

   // Q1.16 unity coefficient
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

   // register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_THRESHOLD = 2'd0,
      REG_ALPHA     = 2'd1,
      REG_HOLD      = 2'd2
   } reg_index_type;

   // pipeline stage loads, shared by the envelope path and the main lanes
   typedef struct packed {
      logic ld_mix;   // transaction enters the mix stage
      logic ld_env;   // mix stage moves into the envelope stage
      logic ld_out;   // envelope stage moves into the output register
      logic open;     // gate decision for the transaction entering the output
   } stage_ctl_type;

endpackage

/* hdl/sngh_if.sv */
`timescale 1ns / 1ps

// Request channel: one stereo frame with its sidechain pair
interface sngh_req_if;
   import sngh_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] side_left;
   logic signed [SAMPLE_W-1:0] side_right;
   logic signed [SAMPLE_W-1:0] main_left_in;
   logic signed [SAMPLE_W-1:0] main_right_in;

   modport source (output valid, side_left, side_right, main_left_in, main_right_in,
                   input ready);
   modport sink   (input valid, side_left, side_right, main_left_in, main_right_in,
                   output ready);
endinterface

// Response channel: gated stereo frame
interface sngh_rsp_if;
   import sngh_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] main_left_out;
   logic signed [SAMPLE_W-1:0] main_right_out;
   logic                       gate_open;

   modport source (output valid, main_left_out, main_right_out, gate_open,
                   input ready);
   modport sink   (input valid, main_left_out, main_right_out, gate_open,
                   output ready);
endinterface

/* hdl/sngh_envelope.sv */
`timescale 1ns / 1ps

module sngh_envelope
   import sngh_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  stage_ctl_type              ctl,
   input  logic signed [SAMPLE_W-1:0] side_left,
   input  logic signed [SAMPLE_W-1:0] side_right,
   input  logic        [ALPHA_W-1:0]  alpha,
   output logic signed [ENV_W-1:0]    envelope
);

   logic signed [SAMPLE_W-1:0]           mix_ff, mix_in;
   logic signed [ENV_W-1:0]              env_ff, env_in;
   logic signed [SAMPLE_W:0]             side_sum;
   logic        [ALPHA_W-1:0]            alpha_sat;
   logic signed [ENV_W-1:0]              mix_wide;
   logic signed [ENV_W:0]                diff;
   logic signed [ENV_W+ALPHA_W+1:0]      prod;
   logic signed [ENV_W+ALPHA_W+1:0]      prod_shr;

   // merge the two sidechain lanes: floor average, always in sample range
   always_comb begin
      side_sum = {side_left[SAMPLE_W-1], side_left}
                 + {side_right[SAMPLE_W-1], side_right};
      mix_in   = side_sum[SAMPLE_W:1];
   end

   // one-pole low-pass: env = mix + alpha * (env - mix), floor after the product
   always_comb begin
      alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      mix_wide  = {mix_ff, {ENV_EXTRA{1'b0}}};
      diff      = {env_ff[ENV_W-1], env_ff} - {mix_wide[ENV_W-1], mix_wide};
      prod      = (ENV_W+ALPHA_W+2)'(diff)
                  * (ENV_W+ALPHA_W+2)'($signed({1'b0, alpha_sat}));
      prod_shr  = prod >>> ENV_EXTRA;
      env_in    = mix_wide + ENV_W'(prod_shr);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_mix) begin
         mix_ff <= mix_in;
      end
   end

   // envelope is block state: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else if (ctl.ld_env) begin
         env_ff <= env_in;
      end
   end

   assign envelope = env_ff;

endmodule

/* hdl/sngh_gate_lane.sv */
`timescale 1ns / 1ps

module sngh_gate_lane
   import sngh_pkg::*;
(
   input  logic                       clock,
   input  stage_ctl_type              ctl,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   logic signed [SAMPLE_W-1:0] mix_stage_ff;
   logic signed [SAMPLE_W-1:0] env_stage_ff;
   logic signed [SAMPLE_W-1:0] out_ff, out_in;

   // pass or mute at the output register
   assign out_in = ctl.open ? env_stage_ff : '0;

   // follow the envelope path stage by stage
   always_ff @(posedge clock) begin
      if (ctl.ld_mix) begin
         mix_stage_ff <= sample_in;
      end
      if (ctl.ld_env) begin
         env_stage_ff <= mix_stage_ff;
      end
      if (ctl.ld_out) begin
         out_ff <= out_in;
      end
   end

   assign sample_out = out_ff;

endmodule

/* hdl/sidechain_noise_gate_hold.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    side_left, side_right, main_left_in, main_right_in
// rsp_bus   out  valid/ready    main_left_out, main_right_out, gate_open
// csr_*     in   csr_write_en   csr_index, csr_write_data (no read-back)
//
// One frame per cycle sustained while rsp_bus.ready holds; three-stage pipeline
// (mix, envelope, output register), each frame passing through them in that order.
// The rate is set by the envelope feedback: one 41x17 multiply and add per cycle.
// Synchronous reset clears the envelope, hold counter and valids, and loads the configuration registers' defaults.
// Each stage moves when the next one is empty or moving, so a stalled response
// blocks only the stages behind it once they fill.

module sidechain_noise_gate_hold
   import sngh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   sngh_req_if.sink         req_bus,
   sngh_rsp_if.source       rsp_bus,
   input  logic             csr_write_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   logic [THR_W-1:0]   threshold_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [HOLD_W-1:0]  hold_samples_ff;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [HOLD_W-1:0]  hold_load;
   logic               mix_valid_ff, env_valid_ff, out_valid_ff;
   logic               mix_ready, env_ready, out_ready;
   logic               env_at_thr;
   logic               gate_open_ff;
   stage_ctl_type      ctl;
   logic signed [ENV_W-1:0]    envelope;
   logic signed [SAMPLE_W-1:0] lane_in  [MAIN_LANES];
   logic signed [SAMPLE_W-1:0] lane_out [MAIN_LANES];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THR_W'(4194304);
         alpha_ff        <= ALPHA_W'(52429);
         hold_samples_ff <= HOLD_W'(48000);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff    <= csr_write_data[THR_W-1:0];
            REG_ALPHA:     alpha_ff        <= csr_write_data[ALPHA_W-1:0];
            REG_HOLD:      hold_samples_ff <= csr_write_data[HOLD_W-1:0];
            default:       ;
         endcase
      end
   end

   // per-stage flow control
   assign out_ready = !out_valid_ff || rsp_bus.ready;
   assign env_ready = !env_valid_ff || out_ready;
   assign mix_ready = !mix_valid_ff || env_ready;

   // threshold compare on the full envelope, then the hold decision
   always_comb begin
      env_at_thr = envelope >= $signed({1'b0, threshold_ff, {ENV_EXTRA{1'b0}}});
      hold_load  = env_at_thr ? hold_samples_ff : hold_ff;
      hold_in    = (hold_load != '0) ? hold_load - HOLD_W'(1) : '0;
   end

   always_comb begin
      ctl.ld_mix = req_bus.valid && mix_ready;
      ctl.ld_env = mix_valid_ff && env_ready;
      ctl.ld_out = env_valid_ff && out_ready;
      ctl.open   = hold_load != '0;
   end

   // stage valids and hold counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
         env_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         hold_ff      <= '0;
      end else begin
         if (mix_ready) begin
            mix_valid_ff <= req_bus.valid;
         end
         if (env_ready) begin
            env_valid_ff <= mix_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= env_valid_ff;
         end
         if (ctl.ld_out) begin
            hold_ff <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         gate_open_ff <= ctl.open;
      end
   end

   // sidechain merge and low-pass
   sngh_envelope u_envelope (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .side_left  (req_bus.side_left),
      .side_right (req_bus.side_right),
      .alpha      (alpha_ff),
      .envelope   (envelope)
   );

   // main audio lanes
   assign lane_in[0] = req_bus.main_left_in;
   assign lane_in[1] = req_bus.main_right_in;

   for (genvar i = 0; i < MAIN_LANES; i++) begin : g_lane
      sngh_gate_lane u_lane (
         .clock      (clock),
         .ctl        (ctl),
         .sample_in  (lane_in[i]),
         .sample_out (lane_out[i])
      );
   end

   assign req_bus.ready          = mix_ready;
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.main_left_out  = lane_out[0];
   assign rsp_bus.main_right_out = lane_out[1];
   assign rsp_bus.gate_open      = gate_open_ff;

   // a closed gate delivers silence
   a_closed_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.gate_open) |->
      (rsp_bus.main_left_out == '0 && rsp_bus.main_right_out == '0))
      else $error("closed gate passed audio");

   // a counter left nonzero means the frame just issued had the gate open
   a_hold_implies_open: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_out |=> (hold_ff == '0 || rsp_bus.gate_open))
      else $error("hold counter running with gate closed");

   // envelope must not move while its frame waits for the output register
   a_env_stable_on_stall: assert property (@(posedge clock) disable iff (reset)
      (env_valid_ff && !out_ready) |=> (env_valid_ff && $stable(envelope)))
      else $error("envelope changed under a stalled frame");

endmodule
